@@ rtl/two_pole_lowpass_multichannel_defines.svh @@
// assertion macros for the two-pole lowpass checker
`ifndef TWO_POLE_LOWPASS_MULTICHANNEL_DEFINES_SVH
`define TWO_POLE_LOWPASS_MULTICHANNEL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TPLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TPLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tplp_pkg.sv @@
// types and constants for the two-pole multichannel lowpass
package tplp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CHANNEL_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDFORWARD_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TWO     = 2'd2;

    localparam logic signed [COEF_W-1:0] FEEDFORWARD_GAIN_RST = 16'sd329;
    localparam logic signed [COEF_W-1:0] FEEDBACK_ONE_RST     = 16'sd25575;
    localparam logic signed [COEF_W-1:0] FEEDBACK_TWO_RST     = -16'sd10508;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CHANNEL_W-1:0]       channel;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       channel_error;
    } out_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } hist_t;

endpackage

@@ rtl/two_pole_lowpass_multichannel.sv @@
// two-pole multichannel lowpass, top level
// an input transaction is registered with its ram read, then held in the output register
// throughput: one transaction per cycle unless stalled, any channel order; same-channel back-to-back uses forwarding
// the limiting path is the ram read followed by three multiplies and the write-back of one history row
// reset: coefficients return to defaults, per-channel valid bits clear so every history reads as zero
// no clearing pass; the block accepts input straight after reset
module two_pole_lowpass_multichannel #(
    parameter int CHANNELS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tplp_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tplp_pkg::out_t                    out_data,
    input  logic                              cfg_we,
    input  logic [tplp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tplp_pkg::COEF_W-1:0]       cfg_data
);

    import tplp_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_W = $bits(hist_t);

    logic signed [COEF_W-1:0] gain_reg;
    logic signed [COEF_W-1:0] fb_one_reg;
    logic signed [COEF_W-1:0] fb_two_reg;

    logic                       s1_valid_reg;
    logic                       s1_err_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       s1_fwd_reg;
    hist_t                      s1_fwd_data_reg;
    logic                       s1_seen_reg;

    logic [CHANNELS-1:0] seen_reg;
    logic                out_valid_reg;
    out_t                out_data_reg;

    logic                     in_ok;
    logic [ADDR_W-1:0]        in_addr;
    logic                     accept;
    logic                     advance;
    logic                     wr_en;
    logic [HIST_W-1:0]        rd_raw;
    hist_t                    rd_hist;
    hist_t                    hist;
    hist_t                    new_hist;
    logic signed [17:0]       tap_sum;
    logic signed [33:0]       prod_b;
    logic signed [31:0]       prod_one;
    logic signed [31:0]       prod_two;
    logic signed [SAMPLE_W-1:0] y;

    assign in_ok   = in_data.channel < CHANNEL_W'(CHANNELS);
    assign in_addr = in_data.channel[ADDR_W-1:0];
    assign advance = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept  = in_valid && in_ready;
    assign wr_en   = s1_valid_reg && !s1_err_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= FEEDFORWARD_GAIN_RST;
            fb_one_reg <= FEEDBACK_ONE_RST;
            fb_two_reg <= FEEDBACK_TWO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FEEDFORWARD_GAIN: gain_reg   <= cfg_data;
                CFG_FEEDBACK_ONE:     fb_one_reg <= cfg_data;
                CFG_FEEDBACK_TWO:     fb_two_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    tplp_ram #(
        .WIDTH  (HIST_W),
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_hist_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (new_hist),
        .re    (accept && in_ok),
        .raddr (in_addr),
        .rdata (rd_raw)
    );

    assign rd_hist = hist_t'(rd_raw);

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            hist = s1_fwd_data_reg;
        end
        else if (s1_seen_reg)
        begin
            hist = rd_hist;
        end
        else
        begin
            hist = '0;
        end
    end

    assign tap_sum  = 18'(s1_x_reg) + (18'(hist.x1) <<< 1) + 18'(hist.x2);
    assign prod_b   = tap_sum * gain_reg;
    assign prod_one = hist.y1 * fb_one_reg;
    assign prod_two = hist.y2 * fb_two_reg;
    assign y = prod_b[FRAC_W+SAMPLE_W-1:FRAC_W] + prod_one[FRAC_W+SAMPLE_W-1:FRAC_W]
             + prod_two[FRAC_W+SAMPLE_W-1:FRAC_W];

    always_comb
    begin
        new_hist.x1 = s1_x_reg;
        new_hist.x2 = hist.x1;
        new_hist.y1 = y;
        new_hist.y2 = hist.y1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (wr_en)
            begin
                seen_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_err_reg      <= !in_ok;
            s1_x_reg        <= in_data.sample_in;
            s1_addr_reg     <= in_addr;
            s1_fwd_reg      <= wr_en && (s1_addr_reg == in_addr);
            s1_fwd_data_reg <= new_hist;
            s1_seen_reg     <= in_ok && seen_reg[in_addr];
        end
        if (advance && s1_valid_reg)
        begin
            out_data_reg.sample_out    <= s1_err_reg ? '0 : y;
            out_data_reg.channel_error <= s1_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/tplp_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module tplp_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tplp_checker.sv @@
// port-level checker for the two-pole lowpass, bound to the top level
`include "two_pole_lowpass_multichannel_defines.svh"

module tplp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input tplp_pkg::out_t out_data
);

    import tplp_pkg::*;

    `TPLP_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_data.channel_error, out_data.sample_out == '0, "bad channel transaction carries nonzero sample")

    `TPLP_ASSERT_NOW(a_ready_only_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input held off without output backpressure")

    `TPLP_ASSERT_NOW(a_empty_ready, clk, rst_n, !out_valid, in_ready, "input not ready while output register empty")

    `TPLP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output transaction changed")

endmodule

bind two_pole_lowpass_multichannel tplp_checker u_tplp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ tb/sv/lowpass_response_checker.sv @@
// channel monitor, per-channel lowpass prediction and result comparison
module lowpass_response_checker #(
    parameter int CHANNELS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  tplp_pkg::in_t                  in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  tplp_pkg::out_t                 out_data,
    input  logic                           cfg_we,
    input  logic [tplp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tplp_pkg::COEF_W-1:0]    cfg_data,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tplp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic signed [COEF_W-1:0]   ff_gain;
    logic signed [COEF_W-1:0]   fb_one;
    logic signed [COEF_W-1:0]   fb_two;
    logic signed [SAMPLE_W-1:0] x_hist1 [CHANNELS];
    logic signed [SAMPLE_W-1:0] x_hist2 [CHANNELS];
    logic signed [SAMPLE_W-1:0] y_hist1 [CHANNELS];
    logic signed [SAMPLE_W-1:0] y_hist2 [CHANNELS];
    out_t                       expected_outputs [$];
    int                         mismatch_count = 0;

    function automatic out_t filter_sample(in_t item);
        out_t                       result;
        logic signed [17:0]         tap_sum;
        logic signed [33:0]         ff_product;
        logic signed [31:0]         fb1_product;
        logic signed [31:0]         fb2_product;
        logic [SAMPLE_W-1:0]        total;
        int                         c;
        result.sample_out    = '0;
        result.channel_error = 1'b1;
        if (item.channel >= CHANNELS)
            return result;
        c           = item.channel;
        tap_sum     = item.sample_in + 2 * x_hist1[c] + x_hist2[c];
        ff_product  = tap_sum * ff_gain;
        fb1_product = y_hist1[c] * fb_one;
        fb2_product = y_hist2[c] * fb_two;
        // floor shift by the fraction width, then wrap each term and the sum
        total = ff_product[29:14] + fb1_product[29:14] + fb2_product[29:14];
        x_hist2[c] = x_hist1[c];
        x_hist1[c] = item.sample_in;
        y_hist2[c] = y_hist1[c];
        y_hist1[c] = total;
        result.sample_out    = total;
        result.channel_error = 1'b0;
        return result;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t expected;
        if (!rst_n)
        begin
            ff_gain = FEEDFORWARD_GAIN_RST;
            fb_one  = FEEDBACK_ONE_RST;
            fb_two  = FEEDBACK_TWO_RST;
            for (int c = 0; c < CHANNELS; c++)
            begin
                x_hist1[c] = '0;
                x_hist2[c] = '0;
                y_hist1[c] = '0;
                y_hist2[c] = '0;
            end
            expected_outputs.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FEEDFORWARD_GAIN: ff_gain = cfg_data;
                    CFG_FEEDBACK_ONE:     fb_one  = cfg_data;
                    CFG_FEEDBACK_TWO:     fb_two  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_outputs.push_back(filter_sample(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    note_mismatch("unexpected transaction", 0, out_data.sample_out);
                end
                else
                begin
                    expected = expected_outputs.pop_front();
                    if (out_data.sample_out !== expected.sample_out)
                        note_mismatch("sample_out", expected.sample_out, out_data.sample_out);
                    if (out_data.channel_error !== expected.channel_error)
                        note_mismatch("channel_error", expected.channel_error,
                                      out_data.channel_error);
                end
            end
            pending <= expected_outputs.size();
            errors  <= mismatch_count;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// stimulus, reset and verdict for the two-pole multichannel lowpass
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tplp_pkg::*;

    localparam int CHANNELS         = 8;
    localparam int IDLE_PERCENT     = 38;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 240;
    localparam int STALL_CYCLES     = 300;
    localparam int TIMEOUT_NS       = 2_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    in_t                   in_data       = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    out_t                  out_data;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [COEF_W-1:0]     cfg_data      = '0;
    int                    errors;
    int                    pending;
    logic                  stall_request = 1'b0;
    logic                  stall_done    = 1'b0;
    logic                  steady        = 1'b0;
    int                    last_channel  = 0;
    logic [SAMPLE_W-1:0]   level         = '0;

    always #2 clk = ~clk;

    two_pole_lowpass_multichannel #(
        .CHANNELS(CHANNELS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lowpass_response_checker #(
        .CHANNELS(CHANNELS)
    ) checker_inst (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                               input logic [CHANNEL_W-1:0] channel);
        in_t item;
        item.sample_in = sample;
        item.channel   = channel;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_coefficients(input logic [COEF_W-1:0] gain,
                                      input logic [COEF_W-1:0] weight_one,
                                      input logic [COEF_W-1:0] weight_two);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FEEDFORWARD_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_index <= CFG_FEEDBACK_ONE;
        cfg_data  <= weight_one;
        @(posedge clk);
        cfg_index <= CFG_FEEDBACK_TWO;
        cfg_data  <= weight_two;
        @(posedge clk);
        // unmapped index must leave every coefficient alone
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_t next_random_item();
        in_t item;
        int  pick;
        pick = $urandom_range(99);
        if (pick < 10)
            item.channel = 8'($urandom_range(255, CHANNELS));
        else if (pick < 35)
            item.channel = 8'(last_channel);
        else
            item.channel = 8'($urandom_range(CHANNELS - 1));
        if (item.channel < CHANNELS)
            last_channel = item.channel;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            item.sample_in = 16'($urandom);
        end
        else if (pick < 50)
        begin
            item.sample_in = $urandom_range(1) ? 16'h7fff : 16'h8000;
        end
        else
        begin
            level = level + 16'($urandom_range(2047)) - 16'd1024;
            item.sample_in = level;
        end
        return item;
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_request && !stall_done)
            begin
                out_ready  <= 1'b0;
                stall_done <= 1'b1;
                for (int held = 0; held < STALL_CYCLES; held++)
                    @(posedge clk);
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("two_pole_lowpass_multichannel regression: fail");
        $finish;
    end

    initial
    begin
        in_t item;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset coefficients, extreme inputs, bad channels, same-channel runs
        send_sample(16'h7fff, 8'd0);
        send_sample(16'h7fff, 8'd0);
        send_sample(16'h7fff, 8'd0);
        send_sample(16'h8000, 8'd0);
        send_sample(16'h8000, 8'd0);
        send_sample(16'h8000, 8'd0);
        send_sample(16'h0000, 8'd0);
        send_sample(16'h8000, 8'(CHANNELS - 1));
        send_sample(16'h7fff, 8'(CHANNELS - 1));
        send_sample(16'h3039, 8'(CHANNELS));
        send_sample(16'hffff, 8'hff);
        send_sample(16'h7fff, 8'h80);
        send_sample(16'h0064, 8'd0);
        send_sample(16'h4000, 8'd1);
        send_sample(16'hc000, 8'd2);
        send_sample(16'h4000, 8'd1);
        send_sample(16'h4000, 8'd1);
        send_sample(16'h0001, 8'd3);
        send_sample(16'hffff, 8'd3);
        send_sample(16'h5555, 8'd4);
        send_sample(16'haaaa, 8'd4);
        send_sample(16'h8000, 8'd5);
        send_sample(16'h7fff, 8'd6);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            case (phase)
                0: write_coefficients(FEEDFORWARD_GAIN_RST, FEEDBACK_ONE_RST,
                                      FEEDBACK_TWO_RST);
                1: write_coefficients(16'h7fff, 16'h8000, 16'h7fff);
                2: write_coefficients(16'h8000, 16'h7fff, 16'h8000);
                3: write_coefficients(16'h0000, 16'h0000, 16'h0000);
                4: write_coefficients(16'h4000, 16'h0000, 16'h0000);
                default: write_coefficients(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            steady <= (phase == 3);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 0 && n == 30)
                    stall_request <= 1'b1;
                item = next_random_item();
                send_sample(item.sample_in, item.channel);
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("two_pole_lowpass_multichannel regression: pass");
        else
            $display("two_pole_lowpass_multichannel regression: fail");
        $finish;
    end

endmodule
